// ===== rtl/rvid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvid_pkg
// Operation codes, opcode and function field constants and funct3 maps for
// the RV32IM instruction decoder.
// ----------------------------------------------------------------------------
package rvid_pkg;

   typedef enum logic [5:0] {
      OP_LUI    = 6'd0,
      OP_AUIPC  = 6'd1,
      OP_JAL    = 6'd2,
      OP_JALR   = 6'd3,
      OP_BEQ    = 6'd4,
      OP_BNE    = 6'd5,
      OP_BLT    = 6'd6,
      OP_BGE    = 6'd7,
      OP_BLTU   = 6'd8,
      OP_BGEU   = 6'd9,
      OP_LB     = 6'd10,
      OP_LH     = 6'd11,
      OP_LW     = 6'd12,
      OP_LBU    = 6'd13,
      OP_LHU    = 6'd14,
      OP_SB     = 6'd15,
      OP_SH     = 6'd16,
      OP_SW     = 6'd17,
      OP_ADDI   = 6'd18,
      OP_SLTI   = 6'd19,
      OP_SLTIU  = 6'd20,
      OP_XORI   = 6'd21,
      OP_ORI    = 6'd22,
      OP_ANDI   = 6'd23,
      OP_SLLI   = 6'd24,
      OP_SRLI   = 6'd25,
      OP_SRAI   = 6'd26,
      OP_ADD    = 6'd27,
      OP_SUB    = 6'd28,
      OP_SLL    = 6'd29,
      OP_SLT    = 6'd30,
      OP_SLTU   = 6'd31,
      OP_XOR    = 6'd32,
      OP_SRL    = 6'd33,
      OP_SRA    = 6'd34,
      OP_OR     = 6'd35,
      OP_AND    = 6'd36,
      OP_MUL    = 6'd37,
      OP_MULH   = 6'd38,
      OP_MULHSU = 6'd39,
      OP_MULHU  = 6'd40,
      OP_DIV    = 6'd41,
      OP_DIVU   = 6'd42,
      OP_REM    = 6'd43,
      OP_REMU   = 6'd44,
      OP_ECALL  = 6'd45,
      OP_NONE   = 6'd46
   } op_type;

   typedef op_type op_map_type [8];

   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_MEXT = 7'h01;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_PRIV = 3'd0;

   localparam op_map_type BRANCH_MAP = '{OP_BEQ, OP_BNE, OP_NONE, OP_NONE,
                                         OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};
   localparam op_map_type LOAD_MAP   = '{OP_LB, OP_LH, OP_LW, OP_NONE,
                                         OP_LBU, OP_LHU, OP_NONE, OP_NONE};
   localparam op_map_type STORE_MAP  = '{OP_SB, OP_SH, OP_SW, OP_NONE,
                                         OP_NONE, OP_NONE, OP_NONE, OP_NONE};
   localparam op_map_type OPIMM_MAP  = '{OP_ADDI, OP_NONE, OP_SLTI, OP_SLTIU,
                                         OP_XORI, OP_NONE, OP_ORI, OP_ANDI};
   localparam op_map_type BASE_MAP   = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                         OP_XOR, OP_SRL, OP_OR, OP_AND};
   localparam op_map_type MEXT_MAP   = '{OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
                                         OP_DIV, OP_DIVU, OP_REM, OP_REMU};

endpackage

// ===== rtl/rv32im_instruction_decoder_core.sv =====
`timescale 1ns / 1ps
// Each word passes the input register, then the result register. Throughput:
// one word per cycle unless rsp_stall holds a waiting result; the two-stage
// pipeline takes a word while a result waits only if the input stage is empty.
// Reset (synchronous, active high) empties both stages; payload is not reset.
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_core
// Classifies one RV32IM instruction word into a dense operation code and
// passes out the rd, rs1 and I-type immediate fields.
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_instruction,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_operation,
   output logic               rsp_handled,
   output logic [4:0]         rsp_dest_reg,
   output logic [4:0]         rsp_src_reg_one,
   output logic signed [11:0] rsp_imm_itype
);

   logic                in_valid_ff;
   logic [31:0]         in_word_ff;
   logic                out_valid_ff;
   rvid_pkg::op_type    out_op_ff;
   rvid_pkg::op_type    out_op_in;
   logic [4:0]          out_rd_ff;
   logic [4:0]          out_rs1_ff;
   logic signed [11:0]  out_imm_ff;
   logic                adv_out;
   logic                adv_in;

   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [4:0]  rd;
   logic [4:0]  rs1;
   logic [11:0] imm;

   assign adv_out   = !out_valid_ff || !rsp_stall;
   assign adv_in    = !in_valid_ff || adv_out;
   assign req_stall = !adv_in;

   assign opc = in_word_ff[6:0];
   assign f3  = in_word_ff[14:12];
   assign f7  = in_word_ff[31:25];
   assign rd  = in_word_ff[11:7];
   assign rs1 = in_word_ff[19:15];
   assign imm = in_word_ff[31:20];

   always_comb begin
      out_op_in = rvid_pkg::OP_NONE;
      unique case (opc)
         rvid_pkg::OPC_LUI:    out_op_in = rvid_pkg::OP_LUI;
         rvid_pkg::OPC_AUIPC:  out_op_in = rvid_pkg::OP_AUIPC;
         rvid_pkg::OPC_JAL:    out_op_in = rvid_pkg::OP_JAL;
         rvid_pkg::OPC_JALR:   out_op_in = rvid_pkg::OP_JALR;
         rvid_pkg::OPC_BRANCH: out_op_in = rvid_pkg::BRANCH_MAP[f3];
         rvid_pkg::OPC_LOAD:   out_op_in = rvid_pkg::LOAD_MAP[f3];
         rvid_pkg::OPC_STORE:  out_op_in = rvid_pkg::STORE_MAP[f3];
         rvid_pkg::OPC_OPIMM: begin
            priority if (f3 == rvid_pkg::F3_SLL) begin
               if (f7 == rvid_pkg::F7_BASE) out_op_in = rvid_pkg::OP_SLLI;
            end else if (f3 == rvid_pkg::F3_SR) begin
               if (f7 == rvid_pkg::F7_BASE)     out_op_in = rvid_pkg::OP_SRLI;
               else if (f7 == rvid_pkg::F7_ALT) out_op_in = rvid_pkg::OP_SRAI;
            end else begin
               out_op_in = rvid_pkg::OPIMM_MAP[f3];
            end
         end
         rvid_pkg::OPC_OP: begin
            if (f7 == rvid_pkg::F7_BASE) begin
               out_op_in = rvid_pkg::BASE_MAP[f3];
            end else if (f7 == rvid_pkg::F7_MEXT) begin
               out_op_in = rvid_pkg::MEXT_MAP[f3];
            end else if (f7 == rvid_pkg::F7_ALT) begin
               if (f3 == rvid_pkg::F3_ADD)     out_op_in = rvid_pkg::OP_SUB;
               else if (f3 == rvid_pkg::F3_SR) out_op_in = rvid_pkg::OP_SRA;
            end
         end
         rvid_pkg::OPC_SYSTEM: begin
            if (f3 == rvid_pkg::F3_PRIV && rd == 5'd0 && rs1 == 5'd0 && imm == 12'd0)
               out_op_in = rvid_pkg::OP_ECALL;
         end
         default: out_op_in = rvid_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv_in)  in_valid_ff  <= req_valid;
         if (adv_out) out_valid_ff <= in_valid_ff;
      end
      if (adv_in && req_valid) in_word_ff <= req_instruction;
      if (adv_out && in_valid_ff) begin
         out_op_ff  <= out_op_in;
         out_rd_ff  <= rd;
         out_rs1_ff <= rs1;
         out_imm_ff <= $signed(imm);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_operation   = out_op_ff;
   assign rsp_handled     = (out_op_ff != rvid_pkg::OP_NONE);
   assign rsp_dest_reg    = out_rd_ff;
   assign rsp_src_reg_one = out_rs1_ff;
   assign rsp_imm_itype   = out_imm_ff;

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && adv_out) |=> out_valid_ff)
      else $error("input stage word lost");

   a_op_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_operation <= 6'd46))
      else $error("operation code out of range");

   a_ecall_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_operation == rvid_pkg::OP_ECALL) |->
      (rsp_dest_reg == 5'd0 && rsp_src_reg_one == 5'd0 && rsp_imm_itype == 12'sd0))
      else $error("ecall with nonzero fields");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !adv_out) |=> (in_valid_ff && $stable(in_word_ff)))
      else $error("input stage changed while blocked");

endmodule
